@@ rtl/core/lmbd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the label map boundary distance block: sizes, widths and
// the command/status structs shared by controller and datapath.
package lmbd_pkg;
    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 512;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int LABEL_W  = 16;
    localparam int POS_W    = 16;
    localparam int SIZE_W   = 10;
    localparam int RAD_W    = 12;
    localparam int D2_W     = 2 * RAD_W;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_RAD  = 2'd2;

    typedef struct packed {
        logic load;      // capture query
        logic rd_centre; // issue centre read, set window
        logic scan_rd;   // issue window read, advance scan
        logic scan_cmp;  // compare the read returned last cycle
        logic sqrt_go;   // start root
        logic sqrt_step; // one root step
    } t_cmd;

    typedef struct packed {
        logic outside;   // empty map or point off the map
        logic scan_last; // current read is the last of the window
        logic sqrt_done;
    } t_sts;
endpackage

@@ rtl/core/label_map_boundary_distance.sv @@
`timescale 1ns / 1ps
// Top level of the label map boundary distance block.
// Depends on lmbd_pkg, lmbd_ctrl and lmbd_dp.
//
// A write item does not hold the input. A query goes from its transfer through
// the window check, the centre read, the scan of the W pixels of the clipped
// window (up to (2R+1)^2 for R = ceil(radius) pixels) and the square root to
// the loading of its result: the label memory gives one read per cycle and
// the square root takes one step per cycle, twelve steps. A query outside the
// map or on an empty map skips the reads and root and loads the radius. The
// input takes a new item in the cycle after the result is loaded. One query
// is in flight at a time; the result register lets the next item in while it waits.
module label_map_boundary_distance import lmbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic [COL_W-1:0]   i_wr_col,
    input  logic [ROW_W-1:0]   i_wr_row,
    input  logic [LABEL_W-1:0] i_wr_label,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [RAD_W-1:0]   o_distance,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [RAD_W-1:0]   i_cfg_data
);
    logic [SIZE_W-1:0] r_cols, r_rows;
    logic [RAD_W-1:0]  r_radius;
    logic              r_valid;
    logic [RAD_W-1:0]  r_dist;
    t_cmd cmd;
    t_sts sts;
    logic busy, load_res, acc, out_free, bypass;
    logic [RAD_W-1:0] dp_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= '0;
            r_rows   <= '0;
            r_radius <= RAD_W'(128);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLS: r_cols   <= i_cfg_data[SIZE_W-1:0];
                CFG_ROWS: r_rows   <= i_cfg_data[SIZE_W-1:0];
                CFG_RAD:  r_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall  = busy;
    assign acc      = i_valid && !busy;
    assign out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (load_res) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
        if (load_res) r_dist <= dp_res;
    end

    lmbd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_query(acc && i_kind), .i_out_free(out_free),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_bypass(bypass), .o_result(load_res)
    );

    lmbd_dp u_dp (
        .i_clk, .i_wr_en(acc && !i_kind),
        .i_wr_col, .i_wr_row, .i_wr_label, .i_pos_x, .i_pos_y,
        .i_cols(r_cols), .i_rows(r_rows), .i_radius(r_radius),
        .i_cmd(cmd), .i_bypass(bypass), .o_sts(sts), .o_result(dp_res)
    );

    assign o_valid    = r_valid;
    assign o_distance = r_dist;
endmodule

@@ rtl/core/lmbd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the label map boundary distance block.
// Depends on lmbd_pkg; sequences one query through the datapath.
module lmbd_ctrl import lmbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_query,      // query accepted this edge
    input  logic i_out_free,   // result register free or leaving
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_bypass,     // answer with the search radius
    output logic o_result      // load result register this cycle
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_CEN  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_bypass, n_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bypass <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bypass <= n_bypass;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bypass = r_bypass;
        o_cmd    = '0;
        o_result = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.outside) begin
                    n_bypass = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_bypass       = 1'b0;
                    o_cmd.rd_centre = 1'b1;
                    n_state        = S_CEN;
                end
            end
            S_CEN: begin
                // centre label arrives; start window reads
                o_cmd.scan_rd = 1'b1;
                n_state       = i_sts.scan_last ? S_LAST : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_cmp = 1'b1;
                if (i_sts.scan_last) n_state = S_LAST;
            end
            S_LAST: begin
                o_cmd.scan_cmp = 1'b1;
                o_cmd.sqrt_go  = 1'b1;
                n_state        = S_ROOT;
            end
            S_ROOT: begin
                if (i_sts.sqrt_done) n_state = S_OUT;
                else o_cmd.sqrt_step = 1'b1;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_result = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_bypass = r_bypass;
endmodule

@@ rtl/core/lmbd_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the label map boundary distance block: label memory,
// window scan, squared-distance minimum and an iterative square root. Uses lmbd_pkg.
module lmbd_dp import lmbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [COL_W-1:0]   i_wr_col,
    input  logic [ROW_W-1:0]   i_wr_row,
    input  logic [LABEL_W-1:0] i_wr_label,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic [SIZE_W-1:0]  i_cols,
    input  logic [SIZE_W-1:0]  i_rows,
    input  logic [RAD_W-1:0]   i_radius,
    input  t_cmd               i_cmd,
    input  logic               i_bypass,
    output t_sts               o_sts,
    output logic [RAD_W-1:0]   o_result
);
    localparam int CW = SIZE_W + 3; // signed coordinate width
    localparam int IR_W = RAD_W - 3; // ceil radius in pixels, up to 256

    logic [LABEL_W-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [LABEL_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  rd_addr;

    logic signed [CW-1:0] r_cx, r_cy, n_cx, n_cy;
    logic [SIZE_W-1:0]    r_cols, r_rows;
    logic [COL_W-1:0]     r_x0, r_x1, r_x, r_px;
    logic [ROW_W-1:0]     r_y0, r_y1, r_y, r_py;
    logic [LABEL_W-1:0]   r_centre;
    logic [D2_W-1:0]      r_best;
    logic [D2_W-1:0]      r_num;
    logic [D2_W-1:0]      r_res;
    logic [D2_W-1:0]      r_bit;

    // centre label is valid in the first scan cycle only
    logic r_cmd_first;

    // Q12.4 round half to even
    function automatic logic signed [CW-1:0] round_q4(input logic [POS_W-1:0] p);
        logic signed [POS_W-1:0] w;
        logic [3:0] f;
        begin
            w = $signed(p) >>> 4;
            f = p[3:0];
            if (f > 4'd8 || (f == 4'd8 && w[0])) w = w + 1'b1;
            round_q4 = CW'(w);
        end
    endfunction

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[{i_wr_row, i_wr_col}] <= i_wr_label;
        r_rdata <= r_mem[rd_addr];
    end

    assign n_cx = round_q4(i_pos_x);
    assign n_cy = round_q4(i_pos_y);

    logic [SIZE_W-1:0] sat_cols, sat_rows;
    assign sat_cols = (i_cols > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : i_cols;
    assign sat_rows = (i_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : i_rows;

    assign o_sts.outside = (r_cols == '0) || (r_rows == '0) || r_cx[CW-1] || r_cy[CW-1] ||
                           (r_cx >= $signed({3'b0, r_cols})) ||
                           (r_cy >= $signed({3'b0, r_rows}));

    logic [IR_W-1:0] irad;
    assign irad = IR_W'((RAD_W + 1)'(i_radius) + 13'd15 >> 4);

    logic signed [CW:0] lo_x, hi_x, lo_y, hi_y;
    assign lo_x = (CW+1)'(r_cx) - (CW+1)'(irad);
    assign hi_x = (CW+1)'(r_cx) + (CW+1)'(irad);
    assign lo_y = (CW+1)'(r_cy) - (CW+1)'(irad);
    assign hi_y = (CW+1)'(r_cy) + (CW+1)'(irad);

    assign rd_addr = i_cmd.rd_centre ? {r_cy[ROW_W-1:0], r_cx[COL_W-1:0]} : {r_y, r_x};
    assign o_sts.scan_last = (r_x == r_x1) && (r_y == r_y1);

    // distance of the pixel whose label is in r_rdata
    logic [COL_W-1:0] dx;
    logic [ROW_W-1:0] dy;
    logic [D2_W+1:0]  d2;
    assign dx = (r_px > r_cx[COL_W-1:0]) ? r_px - r_cx[COL_W-1:0] : r_cx[COL_W-1:0] - r_px;
    assign dy = (r_py > r_cy[ROW_W-1:0]) ? r_py - r_cy[ROW_W-1:0] : r_cy[ROW_W-1:0] - r_py;
    assign d2 = (D2_W+2)'({(D2_W+2-8)'(dx) * (D2_W+2-8)'(dx) +
                           (D2_W+2-8)'(dy) * (D2_W+2-8)'(dy), 8'd0});

    // the partial root runs at full width; only the final root fits RAD_W
    logic [D2_W-1:0] trial;
    assign trial = r_res + r_bit;
    assign o_sts.sqrt_done = (r_bit == '0);
    assign o_result = i_bypass ? i_radius : r_res[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_cols <= sat_cols;
            r_rows <= sat_rows;
            r_best <= D2_W'(i_radius) * D2_W'(i_radius);
        end
        if (i_cmd.rd_centre) begin
            // clip the window to the map
            r_x0 <= lo_x[CW] ? '0 : COL_W'(lo_x);
            r_y0 <= lo_y[CW] ? '0 : ROW_W'(lo_y);
            r_x1 <= (hi_x > $signed({3'b0, r_cols}) - 1) ? COL_W'(r_cols - 1'b1) : COL_W'(hi_x);
            r_y1 <= (hi_y > $signed({3'b0, r_rows}) - 1) ? ROW_W'(r_rows - 1'b1) : ROW_W'(hi_y);
            r_x  <= lo_x[CW] ? '0 : COL_W'(lo_x);
            r_y  <= lo_y[CW] ? '0 : ROW_W'(lo_y);
        end
        if (i_cmd.scan_rd) begin
            if (r_cmd_first) r_centre <= r_rdata;
            r_px <= r_x;
            r_py <= r_y;
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (i_cmd.scan_cmp && (r_rdata != r_centre) && (d2 < (D2_W+2)'(r_best)))
            r_best <= D2_W'(d2);
        if (i_cmd.sqrt_go) begin
            r_num <= (i_cmd.scan_cmp && (r_rdata != r_centre) &&
                      (d2 < (D2_W+2)'(r_best))) ? D2_W'(d2) : r_best;
            r_res <= '0;
            r_bit <= D2_W'(1) << (D2_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_num >= trial) begin
                r_num <= r_num - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) r_cmd_first <= i_cmd.rd_centre;
endmodule

@@ rtl/core/lmbd_checker.sv @@
`timescale 1ns / 1ps
// Port checker for label_map_boundary_distance; bound to the top level.
// Depends on lmbd_pkg for widths.
module lmbd_checker import lmbd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_kind,
    input logic             o_valid,
    input logic             i_stall,
    input logic [RAD_W-1:0] o_distance
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance))
        else $error("result changed while stalled");
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_kind |=> !o_stall)
        else $error("write held the input");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind |=> o_stall)
        else $error("query did not occupy the block");
endmodule

bind label_map_boundary_distance lmbd_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .o_valid, .i_stall, .o_distance
);
